// ===== src/cesd_pkg.sv =====
// Package for the C escape sequence decoder: character codes and decode helpers.
// No dependencies; imported by c_escape_sequence_decoder_core and the testbench.
package cesd_pkg;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X      = 8'h78;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_7      = 8'h37;

  // Octal digits per escape; the last digit index ends the run.
  localparam int unsigned OCT_DIGITS = 3;
  localparam logic [1:0]  OCT_LAST   = 2'(OCT_DIGITS - 1);

  // Hex digit check: returns {is_digit, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    begin
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
        r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
        r = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return r;
    end
  endfunction

  // Simple escape lookup: returns {hit, byte}.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    begin
      case (c)
        8'h27:   r = {1'b1, 8'h27};
        8'h22:   r = {1'b1, 8'h22};
        8'h3F:   r = {1'b1, 8'h3F};
        8'h5C:   r = {1'b1, 8'h5C};
        8'h61:   r = {1'b1, 8'h07};
        8'h62:   r = {1'b1, 8'h08};
        8'h66:   r = {1'b1, 8'h0C};
        8'h6E:   r = {1'b1, 8'h0A};
        8'h72:   r = {1'b1, 8'h0D};
        8'h74:   r = {1'b1, 8'h09};
        8'h76:   r = {1'b1, 8'h0B};
        default: r = 9'b0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== src/c_escape_sequence_decoder_core.sv =====
// C string literal escape decoder, top level.
// A byte is offered on out_valid in the cycle after its character is accepted.
// Throughput: one character per cycle while each gives at most one byte and the output
// accepts; a character that gives two bytes holds the input until the first has left, set by the single
// output port moving one byte per transaction. Depends on cesd_pkg.
// Reset (rst_n low, synchronous): normal mode, counters cleared, max_bytes = 65535.
module c_escape_sequence_decoder_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import cesd_pkg::*;

  localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  typedef enum logic [1:0] {MODE_NORMAL, MODE_BSLASH, MODE_HEX, MODE_OCT} mode_t;

  mode_t                   mode_r, mode_nxt;
  logic [7:0]              esc_r, esc_nxt;
  logic [1:0]              oct_cnt_r, oct_cnt_nxt;
  logic [COUNT_WIDTH-1:0]  emitted_r, emitted_nxt;
  logic [15:0]             max_bytes_r;
  logic [1:0]              res_cnt_r, res_cnt_nxt;
  logic [7:0]              res_b0_r, res_b0_nxt, res_b1_r, res_b1_nxt;

  logic [1:0]  n_pend;
  logic [7:0]  p0, p1;
  logic [4:0]  hx;
  logic [8:0]  se;
  logic        is_oct;
  logic [LW-1:0] limit_w, cap_w, mb_w, cnt_w;
  logic        ok0, ok1;
  logic [1:0]  n_out;
  logic        in_acc, out_acc;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign cfg_ready = 1'b1;

  // Drain one byte per output transaction; accept input once the slot frees up
  assign out_valid    = (res_cnt_r != 2'd0);
  assign out_byte     = res_b0_r;
  assign out_run_last = (res_cnt_r == 2'd1);
  assign in_ready     = (res_cnt_r == 2'd0) || (res_cnt_r == 2'd1 && out_ready);

  // Decode one character against the current mode
  always_comb begin
    n_pend      = 2'd0;
    p0          = CHAR_BSLASH;
    p1          = in_char;
    mode_nxt    = mode_r;
    esc_nxt     = esc_r;
    oct_cnt_nxt = oct_cnt_r;
    hx          = hex_digit(in_char);
    se          = simple_escape(in_char);
    is_oct      = (in_char >= CHAR_0) && (in_char <= CHAR_7);
    if (in_char == CHAR_NUL) begin
      // Flush any pending escape, then return to reset state
      case (mode_r)
        MODE_HEX, MODE_OCT: begin
          n_pend = 2'd1;
          p0     = esc_r;
        end
        MODE_BSLASH: begin
          n_pend = 2'd1;
          p0     = CHAR_BSLASH;
        end
        default: n_pend = 2'd0;
      endcase
      mode_nxt    = MODE_NORMAL;
      esc_nxt     = 8'd0;
      oct_cnt_nxt = 2'd0;
    end else begin
      case (mode_r)
        MODE_NORMAL: begin
          if (in_char == CHAR_BSLASH) begin
            mode_nxt = MODE_BSLASH;
          end else begin
            n_pend = 2'd1;
            p0     = in_char;
          end
        end
        MODE_BSLASH: begin
          mode_nxt = MODE_NORMAL;
          if (in_char == CHAR_X) begin
            mode_nxt = MODE_HEX;
            esc_nxt  = 8'd0;
          end else if (is_oct) begin
            mode_nxt    = MODE_OCT;
            esc_nxt     = {5'd0, in_char[2:0]};
            oct_cnt_nxt = 2'd1;
          end else if (se[8]) begin
            n_pend = 2'd1;
            p0     = se[7:0];
          end else begin
            // Unknown escape: backslash then the character
            n_pend = 2'd2;
            p0     = CHAR_BSLASH;
            p1     = in_char;
          end
        end
        MODE_HEX: begin
          if (hx[4]) begin
            esc_nxt = {esc_r[3:0], hx[3:0]};
          end else begin
            // End of run: emit value, then treat the character as normal
            p0 = esc_r;
            if (in_char == CHAR_BSLASH) begin
              n_pend   = 2'd1;
              mode_nxt = MODE_BSLASH;
            end else begin
              n_pend   = 2'd2;
              mode_nxt = MODE_NORMAL;
            end
          end
        end
        default: begin
          if (is_oct) begin
            esc_nxt = {esc_r[4:0], in_char[2:0]};
            if (oct_cnt_r == OCT_LAST) begin
              n_pend      = 2'd1;
              p0          = {esc_r[4:0], in_char[2:0]};
              mode_nxt    = MODE_NORMAL;
              oct_cnt_nxt = 2'd0;
            end else begin
              oct_cnt_nxt = oct_cnt_r + 2'd1;
            end
          end else begin
            p0          = esc_r;
            oct_cnt_nxt = 2'd0;
            if (in_char == CHAR_BSLASH) begin
              n_pend   = 2'd1;
              mode_nxt = MODE_BSLASH;
            end else begin
              n_pend   = 2'd2;
              mode_nxt = MODE_NORMAL;
            end
          end
        end
      endcase
    end
  end

  // Apply the per-string byte limit
  always_comb begin
    cap_w   = LW'({COUNT_WIDTH{1'b1}});
    mb_w    = LW'(max_bytes_r);
    limit_w = (mb_w < cap_w) ? mb_w : cap_w;
    cnt_w   = LW'(emitted_r);
    ok0     = cnt_w < limit_w;
    ok1     = ({1'b0, cnt_w} + (LW+1)'(1)) < {1'b0, limit_w};
    case (n_pend)
      2'd2:    n_out = ok1 ? 2'd2 : (ok0 ? 2'd1 : 2'd0);
      2'd1:    n_out = ok0 ? 2'd1 : 2'd0;
      default: n_out = 2'd0;
    endcase
    if (in_char == CHAR_NUL) begin
      emitted_nxt = '0;
    end else begin
      emitted_nxt = emitted_r + COUNT_WIDTH'(n_out);
    end
  end

  // Result slot: load on input transaction, shift on output transaction
  always_comb begin
    res_cnt_nxt = res_cnt_r;
    res_b0_nxt  = res_b0_r;
    res_b1_nxt  = res_b1_r;
    if (out_acc) begin
      res_cnt_nxt = res_cnt_r - 2'd1;
      res_b0_nxt  = res_b1_r;
    end
    if (in_acc) begin
      res_cnt_nxt = n_out;
      res_b0_nxt  = p0;
      res_b1_nxt  = p1;
    end
  end

  // Hold control state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NORMAL;
      esc_r       <= 8'd0;
      oct_cnt_r   <= 2'd0;
      emitted_r   <= '0;
      max_bytes_r <= 16'hFFFF;
      res_cnt_r   <= 2'd0;
    end else begin
      if (in_acc) begin
        mode_r    <= mode_nxt;
        esc_r     <= esc_nxt;
        oct_cnt_r <= oct_cnt_nxt;
        emitted_r <= emitted_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        max_bytes_r <= cfg_data;
      end
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_b0_r <= res_b0_nxt;
    res_b1_r <= res_b1_nxt;
  end

  // Checks on the decoder's own state
  a_res_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r != 2'd3) else $error("result slot count out of range");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r == 2'd2 |-> !in_ready) else $error("input taken while two bytes pending");

  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_char == CHAR_NUL |=>
      mode_r == MODE_NORMAL && emitted_r == '0 && esc_r == 8'd0)
    else $error("string end did not clear state");

  a_oct_count: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_OCT |-> (oct_cnt_r == 2'd1 || oct_cnt_r == 2'd2))
    else $error("octal digit count invalid in octal run");

  a_oct_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_OCT |-> oct_cnt_r == 2'd0)
    else $error("octal digit count left over outside octal run");

endmodule

// ===== dv/tb.sv =====
// Testbench for c_escape_sequence_decoder_core: directed and random character streams,
// checked byte by byte against a behavioural decoder held in this file.
// Depends on cesd_pkg and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cesd_pkg::*;

  localparam int COUNT_WIDTH   = 16;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_CHARS   = 115;
  localparam int PHASE_COUNT   = 10;

  typedef enum logic [1:0] {DEC_NORMAL, DEC_BSLASH, DEC_HEX, DEC_OCT} dec_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  c_escape_sequence_decoder_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Characters waiting to be sent and bytes the decoder should produce
  logic [7:0] char_feed [$];
  dec_byte_t  decoded_q [$];
  int         chars_queued = 0;
  int         fail_count = 0;

  // Characters that follow a backslash as simple escapes
  logic [7:0] simple_chars [11] = '{8'h27, 8'h22, 8'h3F, 8'h5C, 8'h61, 8'h62,
                                    8'h66, 8'h6E, 8'h72, 8'h74, 8'h76};

  // Decoder state mirrored by the testbench
  dec_mode_e              dec_mode = DEC_NORMAL;
  logic [7:0]             dec_value = 8'h00;
  logic [1:0]             dec_oct_cnt = 2'd0;
  logic [COUNT_WIDTH-1:0] dec_emitted = '0;
  logic [15:0]            byte_limit = 16'hFFFF;
  logic [7:0]             dec_staged [$];

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // A character in normal mode: open an escape or pass it through
  task automatic take_plain(input logic [7:0] c);
    if (c == CHAR_BSLASH) begin
      dec_mode = DEC_BSLASH;
    end else begin
      dec_staged.push_back(c);
    end
  endtask

  // Decode one accepted character and queue the bytes it releases
  task automatic decode_char(input logic [7:0] c);
    longint     cap;
    longint     lim;
    int         nib;
    logic [1:0] cnt_next;
    logic [7:0] kept [$];
    cap = (longint'(1) << COUNT_WIDTH) - 1;
    lim = (longint'(byte_limit) < cap) ? longint'(byte_limit) : cap;
    dec_staged.delete();
    if (c == CHAR_NUL) begin
      // flush whatever escape is pending
      if (dec_mode == DEC_HEX || dec_mode == DEC_OCT) begin
        dec_staged.push_back(dec_value);
      end else if (dec_mode == DEC_BSLASH) begin
        dec_staged.push_back(CHAR_BSLASH);
      end
    end else begin
      case (dec_mode)
        DEC_NORMAL: begin
          take_plain(c);
        end
        DEC_BSLASH: begin
          dec_mode = DEC_NORMAL;
          if (c == CHAR_X) begin
            dec_mode  = DEC_HEX;
            dec_value = 8'h00;
          end else if (c >= CHAR_0 && c <= CHAR_7) begin
            dec_mode    = DEC_OCT;
            dec_value   = c - CHAR_0;
            dec_oct_cnt = 2'd1;
          end else begin
            case (c)
              8'h27, 8'h22, 8'h3F, 8'h5C: dec_staged.push_back(c);
              8'h61: dec_staged.push_back(8'h07);  // a
              8'h62: dec_staged.push_back(8'h08);  // b
              8'h66: dec_staged.push_back(8'h0C);  // f
              8'h6E: dec_staged.push_back(8'h0A);  // n
              8'h72: dec_staged.push_back(8'h0D);  // r
              8'h74: dec_staged.push_back(8'h09);  // t
              8'h76: dec_staged.push_back(8'h0B);  // v
              default: begin
                // unknown escape: keep the backslash and the character
                dec_staged.push_back(CHAR_BSLASH);
                dec_staged.push_back(c);
              end
            endcase
          end
        end
        DEC_HEX: begin
          nib = -1;
          if (c >= 8'h30 && c <= 8'h39) begin
            nib = c - 8'h30;
          end else if (c >= 8'h61 && c <= 8'h66) begin
            nib = c - 8'h57;
          end else if (c >= 8'h41 && c <= 8'h46) begin
            nib = c - 8'h37;
          end
          if (nib >= 0) begin
            dec_value = {dec_value[3:0], 4'(nib)};
          end else begin
            dec_staged.push_back(dec_value);
            dec_mode = DEC_NORMAL;
            take_plain(c);
          end
        end
        default: begin
          // octal run: the third digit closes it at once
          if (c >= CHAR_0 && c <= CHAR_7) begin
            dec_value   = {dec_value[4:0], c[2:0]};
            cnt_next    = dec_oct_cnt + 2'd1;
            dec_oct_cnt = cnt_next;
            if (cnt_next == 2'd3 || cnt_next == 2'd0) begin
              dec_staged.push_back(dec_value);
              dec_mode    = DEC_NORMAL;
              dec_oct_cnt = 2'd0;
            end
          end else begin
            dec_staged.push_back(dec_value);
            dec_mode    = DEC_NORMAL;
            dec_oct_cnt = 2'd0;
            take_plain(c);
          end
        end
      endcase
    end
    // drop bytes beyond the per-string limit
    foreach (dec_staged[i]) begin
      if (longint'(dec_emitted) < lim) begin
        dec_emitted++;
        kept.push_back(dec_staged[i]);
      end
    end
    foreach (kept[i]) begin
      decoded_q.push_back(dec_byte_t'{data: kept[i], last: (i == kept.size() - 1)});
    end
    if (c == CHAR_NUL) begin
      dec_mode    = DEC_NORMAL;
      dec_value   = 8'h00;
      dec_oct_cnt = 2'd0;
      dec_emitted = '0;
    end
  endtask

  // Driver: present the next character once its gap has run out
  int tx_gap = 0;
  int tx_count = 0;
  bit tx_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_char(in_char);
        tx_count++;
        if (tx_count % 50 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
        end
        tx_gap = tx_calm ? 0 : int'($urandom_range(0, 15));
      end
      // hold a transaction that has not been taken yet
      if (!(in_valid && !in_ready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (char_feed.size() != 0) begin
          in_valid <= 1'b1;
          in_char  <= char_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transaction with the oldest decoded byte
  int   rx_stall = 0;
  int   rx_count = 0;
  bit   rx_calm = 1'b0;
  logic rx_hold = 1'b0;

  always @(posedge clk) begin : rx_proc
    dec_byte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("out_byte: no byte expected, got %02h", out_byte);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            fail_count++;
          end
          if (out_run_last !== want.last) begin
            $error("out_run_last: expected %0b, got %0b", want.last, out_run_last);
            fail_count++;
          end
        end
        rx_count++;
        if (rx_count % 50 == 0) begin
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        rx_stall = rx_calm ? 0 : int'($urandom_range(0, 15));
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      out_ready <= (rx_stall == 0) && !rx_hold;
    end
  end

  // Back-pressure: twice, hold the output off for a long stretch
  int hold_left = 0;
  int squeeze_done = 0;
  int squeeze_seen = 0;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      squeeze_seen++;
    end
    if (hold_left > 0) begin
      hold_left--;
    end else if (squeeze_done < 2 && squeeze_seen >= 300 + 500 * squeeze_done) begin
      hold_left = HOLD_CYCLES;
      squeeze_done++;
    end
    rx_hold <= (hold_left > 0);
  end

  // Watchdog: end the run if no transaction moves for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_char(input logic [7:0] c);
    char_feed.push_back(c);
    chars_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i]);
    end
  endtask

  // Wait until every character is sent and every byte has come out
  task automatic wait_idle();
    while (char_feed.size() != 0 || in_valid || decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write max_bytes while the decoder is idle
  task automatic write_limit(input logic [15:0] v);
    wait_idle();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    byte_limit = v;
  endtask

  // One string: mostly well-formed escapes with random content, some noise
  task automatic queue_string();
    int  pieces;
    int  pick;
    int  digits;
    int  r;
    bit  closed;
    pieces = $urandom_range(1, 10);
    closed = 1'b0;
    for (int p = 0; p < pieces && !closed; p++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        r = $urandom_range(1, 255);
        push_char((r == CHAR_BSLASH) ? 8'h7E : 8'(r));
      end else if (pick < 45) begin
        push_char(CHAR_BSLASH);
        push_char(simple_chars[$urandom_range(0, 10)]);
      end else if (pick < 60) begin
        push_char(CHAR_BSLASH);
        push_char(CHAR_X);
        digits = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
        for (int d = 0; d < digits; d++) begin
          r = $urandom_range(0, 21);
          if (r < 10) begin
            push_char(8'(8'h30 + r));
          end else if (r < 16) begin
            push_char(8'(8'h61 + r - 10));
          end else begin
            push_char(8'(8'h41 + r - 16));
          end
        end
      end else if (pick < 75) begin
        push_char(CHAR_BSLASH);
        digits = $urandom_range(1, 3);
        for (int d = 0; d < digits; d++) begin
          push_char(8'(CHAR_0 + $urandom_range(0, 7)));
        end
      end else if (pick < 85) begin
        push_char(CHAR_BSLASH);
        if ($urandom_range(0, 3) == 0) begin
          push_char(8'(8'h38 + $urandom_range(0, 1)));
        end else begin
          push_char(8'($urandom_range(1, 255)));
        end
      end else if (pick < 95) begin
        push_char(8'($urandom_range(0, 255)));
      end else begin
        // trailing backslash closes the string
        push_char(CHAR_BSLASH);
        push_char(CHAR_NUL);
        closed = 1'b1;
      end
    end
    if (!closed && $urandom_range(0, 7) != 0) begin
      push_char(CHAR_NUL);
    end
  endtask

  // Stimulus: reset, directed strings, then random phases at several limits
  initial begin
    logic [15:0] lim;
    int          target;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // extremes of the character, hex run with no digits flushed by NUL
    push_char(8'hFF);
    push_char(8'h01);
    push_text("\\x");
    push_char(CHAR_NUL);
    // long hex run keeping its low byte, ended by a plain character
    push_text("\\xFf1G");
    // third octal digit, value wraps to 8 bits
    push_text("\\777");
    // digit 8 is not octal
    push_text("\\8");
    // octal run ended by a new escape
    push_text("\\4\\n");
    // octal run flushed by NUL
    push_text("\\12");
    push_char(CHAR_NUL);
    // unknown escape, then a trailing backslash
    push_text("\\q\\");
    push_char(CHAR_NUL);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: lim = 16'h0000;
        1: lim = 16'h0001;
        2: lim = 16'h0002;
        3: lim = 16'h0005;
        4: lim = 16'hFFFF;
        5: lim = 16'($urandom_range(0, 31));
        6: lim = 16'($urandom_range(0, 65535));
        7: lim = 16'hFFFE;
        8: lim = 16'($urandom_range(3, 12));
        default: lim = 16'hFFFF;
      endcase
      write_limit(lim);
      target = chars_queued + PHASE_CHARS;
      while (chars_queued < target) begin
        queue_string();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cesd_pkg.sv
src/c_escape_sequence_decoder_core.sv
dv/tb.sv
